/* sv/qmdb_pkg.sv */
`default_nettype none
package qmdb_pkg;
  localparam int unsigned PosW = 20;
  localparam int unsigned LimW = 24;
  localparam int unsigned DistW = 21;
  localparam int unsigned FacW = 16;
  localparam logic [LimW-1:0] Max24 = 24'hFFFFFF;
  localparam logic [18:0] AccConst = 19'd378372;
  localparam logic [LimW-1:0] MinDurReset = 24'd32768;
  localparam logic [FacW-1:0] FactorReset = 16'd19661;
  localparam logic CfgMinDur = 1'b0;
  localparam logic CfgFactor = 1'b1;

  typedef struct packed {
    logic [DistW-1:0] span;
    logic [LimW-1:0] vel;
    logic [LimW-1:0] acc;
    logic [LimW-1:0] jerk;
    logic last;
  } job_t;
endpackage
`default_nettype wire

/* sv/qmdb_front.sv */
`default_nettype none
module qmdb_front (
  input wire logic clk,
  input wire logic rst,
  input wire logic valid,
  output logic stall,
  input wire logic signed [qmdb_pkg::PosW-1:0] start_position,
  input wire logic signed [qmdb_pkg::PosW-1:0] goal_position,
  input wire logic [qmdb_pkg::LimW-1:0] velocity_limit,
  input wire logic [qmdb_pkg::LimW-1:0] acceleration_limit,
  input wire logic [qmdb_pkg::LimW-1:0] jerk_limit,
  input wire logic last_joint,
  output logic q_valid,
  input wire logic q_pop,
  output qmdb_pkg::job_t q_job
);
  import qmdb_pkg::*;
  // two-entry queue between front and back
  job_t slot [2];
  logic [1:0] count;
  logic rd, wr;
  logic signed [PosW:0] diff;
  job_t job_in;

  always_comb begin
    diff = {goal_position[PosW-1], goal_position}
           - {start_position[PosW-1], start_position};
    job_in.span = diff[PosW] ? DistW'(-diff) : DistW'(diff);
    job_in.vel = velocity_limit;
    job_in.acc = acceleration_limit;
    job_in.jerk = jerk_limit;
    job_in.last = last_joint;
  end

  assign stall = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_job = slot[rd];
  assign wr = rd ^ count[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      rd <= 1'b0;
    end else begin
      count <= count + 2'((valid && !stall) ? 1 : 0) - 2'(q_pop ? 1 : 0);
      if (q_pop) rd <= !rd;
    end
    if (valid && !stall) slot[wr] <= job_in;
  end
endmodule
`default_nettype wire

/* sv/qmdb_back.sv */
`default_nettype none
module qmdb_back (
  input wire logic clk,
  input wire logic rst,
  input wire logic q_valid,
  output logic q_pop,
  input wire qmdb_pkg::job_t q_job,
  input wire logic [qmdb_pkg::LimW-1:0] min_dur,
  input wire logic [qmdb_pkg::FacW-1:0] factor,
  output logic out_valid,
  input wire logic out_stall,
  output logic [qmdb_pkg::LimW-1:0] move_duration,
  output logic saturated
);
  import qmdb_pkg::*;
  typedef enum logic [3:0] {
    S_IDLE, S_VDIV, S_ADIV, S_ASQ, S_JDIV1, S_JDIV2, S_JCB, S_MUL, S_FOLD, S_OUT
  } state_t;
  state_t state;
  job_t job;
  // restoring divider: remainder, numerator shifter, quotient
  logic [LimW:0] rem;
  logic [95:0] num;
  logic [71:0] quo;
  logic [6:0] step;
  logic [LimW-1:0] tv, ta, tj, root, peak, runmax;
  logic sat, satseen, first;
  logic [47:0] sq_x;
  logic [47:0] cq_hi;
  logic [LimW-1:0] cq_lo;
  logic [4:0] bit_i;
  logic [LimW:0] rem_sh;
  logic [LimW:0] rem_sub;
  logic [LimW-1:0] divisor;
  logic [LimW-1:0] trial;
  logic [47:0] trial_sq;
  logic jph;
  logic [47:0] cb_sq;
  logic [47:0] cb_hi;
  logic [47:0] cb_lo;
  logic [71:0] trial_cb;
  logic [71:0] cq_full;
  logic [39:0] scaled;
  logic [LimW-1:0] scaled_c;
  logic [LimW-1:0] fold_base;
  logic [LimW-1:0] fold_max;
  logic fold_sat;

  always_comb begin
    unique case (state)
      S_VDIV: divisor = job.vel;
      S_ADIV: divisor = job.acc;
      default: divisor = job.jerk;
    endcase
    rem_sh = {rem[LimW-1:0], num[95]};
    rem_sub = rem_sh - {1'b0, divisor};
    trial = root | (LimW'(1) << bit_i);
    trial_sq = 48'(trial) * 48'(trial);
    // cube from the registered square, split into two 24x24 products
    cb_hi = 48'(cb_sq[47:24]) * 48'(trial);
    cb_lo = 48'(cb_sq[23:0]) * 48'(trial);
    trial_cb = {cb_hi, 24'd0} + 72'(cb_lo);
    cq_full = {cq_hi, cq_lo};
    scaled = 40'(peak) * 40'(factor);
    scaled_c = (|scaled[39:38]) ? Max24 : scaled[37:14];
    fold_base = first ? min_dur : runmax;
    fold_max = (scaled_c > fold_base) ? scaled_c : fold_base;
    fold_sat = (first ? 1'b0 : satseen) | sat | (|scaled[39:38]);
  end

  assign q_pop = (state == S_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      first <= 1'b1;
      satseen <= 1'b0;
      runmax <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (q_valid) begin
          job <= q_job;
          sat <= 1'b0;
          state <= S_VDIV;
          rem <= '0;
          quo <= '0;
          num <= 96'(({28'd0, q_job.span} * 49'd15) << 13) << 56;
          step <= 7'd39;
        end
        S_VDIV, S_ADIV, S_JDIV1, S_JDIV2: begin
          if (step == 7'd0 || divisor == '0) begin
            quo <= '0;
            unique case (state)
              S_VDIV: begin
                if (job.vel == '0 || |quo[38:23]) begin
                  tv <= Max24;
                  sat <= 1'b1;
                end else tv <= {quo[22:0], !rem_sub[LimW]};
                rem <= '0;
                num <= 96'(({40'd0, job.span} * 61'(AccConst)) << 16) << 40;
                step <= 7'd55;
                state <= S_ADIV;
              end
              S_ADIV: begin
                rem <= '0;
                if (job.acc == '0 || |quo[54:47]) begin
                  ta <= Max24;
                  sat <= 1'b1;
                  num <= 96'(({44'd0, job.span} * 65'd60) << 24) << 45;
                  step <= 7'd50;
                  state <= S_JDIV1;
                end else begin
                  sq_x <= {quo[46:0], !rem_sub[LimW]};
                  root <= '0;
                  bit_i <= 5'd23;
                  state <= S_ASQ;
                end
              end
              S_JDIV1: begin
                if (job.jerk == '0 || |quo[49:47]) begin
                  rem <= '0;
                  tj <= Max24;
                  sat <= 1'b1;
                  state <= S_MUL;
                end else begin
                  // keep the remainder for the fractional quotient
                  cq_hi <= {quo[46:0], !rem_sub[LimW]};
                  rem <= (!rem_sub[LimW]) ? rem_sub : rem_sh;
                  num <= '0;
                  step <= 7'd23;
                  state <= S_JDIV2;
                end
              end
              default: begin
                rem <= '0;
                cq_lo <= {quo[22:0], !rem_sub[LimW]};
                root <= '0;
                bit_i <= 5'd23;
                jph <= 1'b0;
                state <= S_JCB;
              end
            endcase
          end else begin
            // one quotient bit per cycle
            if (!rem_sub[LimW]) begin
              rem <= rem_sub;
              quo <= {quo[70:0], 1'b1};
            end else begin
              rem <= rem_sh;
              quo <= {quo[70:0], 1'b0};
            end
            num <= num << 1;
            step <= step - 7'd1;
          end
        end
        S_ASQ: begin
          if (trial_sq <= sq_x) root <= trial;
          bit_i <= bit_i - 5'd1;
          if (bit_i == 5'd0) begin
            ta <= (trial_sq <= sq_x) ? trial : root;
            rem <= '0;
            quo <= '0;
            num <= 96'(({44'd0, job.span} * 65'd60) << 24) << 45;
            step <= 7'd50;
            state <= S_JDIV1;
          end
        end
        S_JCB: begin
          // per bit: register the square, then cube and compare
          if (!jph) begin
            cb_sq <= trial_sq;
            jph <= 1'b1;
          end else begin
            if (trial_cb <= cq_full) root <= trial;
            bit_i <= bit_i - 5'd1;
            jph <= 1'b0;
            if (bit_i == 5'd0) begin
              tj <= (trial_cb <= cq_full) ? trial : root;
              state <= S_MUL;
            end
          end
        end
        S_MUL: begin
          peak <= (tv >= ta && tv >= tj) ? tv : ((ta >= tj) ? ta : tj);
          state <= S_FOLD;
        end
        S_FOLD: begin
          if (job.last) begin
            move_duration <= fold_max;
            saturated <= fold_sat;
            out_valid <= 1'b1;
            first <= 1'b1;
            runmax <= '0;
            satseen <= 1'b0;
            state <= S_OUT;
          end else begin
            runmax <= fold_max;
            satseen <= fold_sat;
            first <= 1'b0;
            state <= S_IDLE;
          end
        end
        S_OUT: if (!out_stall) begin
          out_valid <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* sv/quintic_move_duration_bound.sv */
`default_nettype none
// Minimum-duration bound for a rest-to-rest quintic move. One item is one
// joint; the item marked last_joint yields one result: the largest scaled
// bound over the move (floored at the minimum-duration register) and a
// saturation flag. Per joint the back end pops the item, runs a
// one-bit-per-cycle restoring divider through four divisions (40, 56, 51
// and 24 steps), a 24-step square root search and a 24-bit cube root
// search (each bit squared, then cubed and compared), then picks the peak
// and folds it in. A last joint then holds its result until taken. A zero
// limit or an overflowing quotient skips the rest of that bound. A two-entry
// queue lets the front take items meanwhile.
module quintic_move_duration_bound (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  output logic in_stall,
  input wire logic signed [qmdb_pkg::PosW-1:0] start_position,
  input wire logic signed [qmdb_pkg::PosW-1:0] goal_position,
  input wire logic [qmdb_pkg::LimW-1:0] velocity_limit,
  input wire logic [qmdb_pkg::LimW-1:0] acceleration_limit,
  input wire logic [qmdb_pkg::LimW-1:0] jerk_limit,
  input wire logic last_joint,
  input wire logic cfg_we,
  input wire logic cfg_index,
  input wire logic [qmdb_pkg::LimW-1:0] cfg_data,
  output logic out_valid,
  input wire logic out_stall,
  output logic [qmdb_pkg::LimW-1:0] move_duration,
  output logic saturated
);
  import qmdb_pkg::*;
  logic [LimW-1:0] min_dur;
  logic [FacW-1:0] factor;
  logic q_valid, q_pop;
  job_t q_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_dur <= MinDurReset;
      factor <= FactorReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgMinDur: min_dur <= cfg_data;
        CfgFactor: factor <= cfg_data[FacW-1:0];
        default: ;
      endcase
    end
  end

  qmdb_front u_front (
    .clk, .rst, .valid(in_valid), .stall(in_stall), .start_position,
    .goal_position, .velocity_limit, .acceleration_limit, .jerk_limit,
    .last_joint, .q_valid, .q_pop, .q_job
  );

  qmdb_back u_back (
    .clk, .rst, .q_valid, .q_pop, .q_job, .min_dur, .factor,
    .out_valid, .out_stall, .move_duration, .saturated
  );

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(move_duration))
    else $error("result dropped while stalled");
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("pop from empty queue");
  a_floor: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) && $stable(min_dur) |-> move_duration >= min_dur)
    else $error("duration below floor");
endmodule
`default_nettype wire
